[rtl/rtprb_pkg.sv]
// Package: states and constants of the RTP reorder buffer.
`default_nettype none
package rtprb_pkg;
    localparam int SEQ_BITS  = 16;
    localparam int MASK_SPAN = 16;
    localparam int RESULT_CAP = 64;

    localparam logic [2:0] CFG_REPAIR_PT = 3'd0;
    localparam logic [2:0] CFG_JUMP_TOL  = 3'd1;
    localparam logic [2:0] CFG_WAIT_LIM  = 3'd2;
    localparam logic [2:0] CFG_NACK_PER  = 3'd3;
    localparam logic [2:0] CFG_SKIP_LIM  = 3'd4;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ARR_RD,
        S_ARR_WR,
        S_DR_RD,
        S_DR_CHK,
        S_DR_HRD,
        S_DR_OUT,
        S_WAIT_DEC,
        S_SK_STEP,
        S_SK_RD,
        S_SK_CHK,
        S_SK_HRD,
        S_SK_OUT,
        S_TR_RD,
        S_TR_CHK,
        S_NK_START,
        S_NK_RD,
        S_NK_CHK,
        S_NK_MRD,
        S_NK_MCHK,
        S_NK_EMIT,
        S_NK_OUT,
        S_FIN_FLAG,
        S_FIN_OUT
    } t_state;
endpackage
`default_nettype wire

[rtl/rtprb_store.sv]
// Sequence store: valid bit and buffer handle per sequence number, one port.
`default_nettype none
module rtprb_store #(
    parameter int HANDLE_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire  [rtprb_pkg::SEQ_BITS-1:0]       i_addr,
    input  wire                                  i_we,
    input  wire                                  i_wvalid,
    input  wire                                  i_whandle_en,
    input  wire  [HANDLE_BITS-1:0]               i_whandle,
    output logic                                 o_valid,
    output logic [HANDLE_BITS-1:0]               o_handle
);
    logic                   r_valid_mem  [2**rtprb_pkg::SEQ_BITS];
    logic [HANDLE_BITS-1:0] r_handle_mem [2**rtprb_pkg::SEQ_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_valid_mem[i_addr] <= i_wvalid;
        end
        o_valid <= r_valid_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_whandle_en) begin
            r_handle_mem[i_addr] <= i_whandle;
        end
        o_handle <= r_handle_mem[i_addr];
    end
endmodule
`default_nettype wire

[rtl/rtp_reorder_buffer_nack.sv]
// Top level: RTP reorder buffer with in-order release, skip and generic NACK.
// After reset the block sweeps the 65536-entry valid store, one entry a cycle,
// before it takes its first item; configuration is taken meanwhile. An arrival
// passes accept, compare (an old packet is dropped) and store write; a repair
// packet or a tick before the first packet is dropped at accept. A tick walks
// the store through its one port: a release reads, checks, clears and sends
// each number; a skip steps, reads and checks each; a NACK scan reads and
// checks each examined number and each mask bit. Results come at most one a
// cycle, sent once the next is found or at finish and held until taken.
`default_nettype none
module rtp_reorder_buffer_nack #(
    parameter int HANDLE_BITS   = 16,
    parameter int RELEASE_BURST = 32,
    parameter int NACK_ITEMS    = 31
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire                    i_req_type,
    input  wire  [15:0]            i_seq_num,
    input  wire  [6:0]             i_payload_kind,
    input  wire  [HANDLE_BITS-1:0] i_buf_handle,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [2:0]             i_cfg_index,
    input  wire  [14:0]            i_cfg_data,
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic                   o_kind,
    output logic [15:0]            o_out_seq,
    output logic [HANDLE_BITS-1:0] o_out_handle,
    output logic [15:0]            o_lost_mask,
    output logic                   o_truncated,
    output logic                   o_last
);
    localparam int CNT_BITS = 7;

    rtprb_pkg::t_state r_state, n_state;

    logic [6:0]  r_repair_pt;
    logic [14:0] r_jump_tol;
    logic [9:0]  r_wait_lim, r_nack_per, r_skip_lim;

    logic        r_started, n_started;
    logic [15:0] r_expected, n_expected;
    logic [15:0] r_last_recv, n_last_recv;
    logic [15:0] r_last_out, n_last_out;
    logic [9:0]  r_wait_ticks, n_wait_ticks;
    logic [9:0]  r_nack_ticks, n_nack_ticks;

    logic [15:0] r_in_seq, n_in_seq;
    logic [HANDLE_BITS-1:0] r_in_handle, n_in_handle;

    logic [16:0] r_cursor, n_cursor;
    logic [15:0] r_pid, n_pid;
    logic [15:0] r_mask, n_mask;
    logic [4:0]  r_mbit, n_mbit;
    logic [9:0]  r_skip_cnt, n_skip_cnt;
    logic [CNT_BITS-1:0] r_n, n_n;
    logic [CNT_BITS-1:0] r_made, n_made;
    logic [CNT_BITS-1:0] r_cap, n_cap;
    logic        r_skipped, n_skipped;
    logic        r_pend, n_pend;
    logic        r_do_nack, n_do_nack;

    logic        r_pv, n_pv;
    logic        r_p_kind, n_p_kind;
    logic [15:0] r_p_seq, n_p_seq;
    logic [HANDLE_BITS-1:0] r_p_handle, n_p_handle;
    logic [15:0] r_p_mask, n_p_mask;
    logic        r_p_trunc, n_p_trunc;

    logic        r_ov, n_ov;
    logic        r_o_kind, n_o_kind;
    logic [15:0] r_o_seq, n_o_seq;
    logic [HANDLE_BITS-1:0] r_o_handle, n_o_handle;
    logic [15:0] r_o_mask, n_o_mask;
    logic        r_o_trunc, n_o_trunc;
    logic        r_o_last, n_o_last;

    logic [15:0] s_addr;
    logic        s_we, s_wvalid, s_hen;
    logic        s_valid;
    logic [HANDLE_BITS-1:0] s_handle;

    rtprb_store #(.HANDLE_BITS(HANDLE_BITS)) u_store (
        .i_clk       (i_clk),
        .i_addr      (s_addr),
        .i_we        (s_we),
        .i_wvalid    (s_wvalid),
        .i_whandle_en(s_hen),
        .i_whandle   (r_in_handle),
        .o_valid     (s_valid),
        .o_handle    (s_handle)
    );

    logic        out_free;
    logic [16:0] diff_abs;
    logic        old_pkt;
    logic [16:0] wrap_lim;

    assign out_free    = !r_ov || i_ready;
    assign o_ready     = (r_state == rtprb_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ov;
    assign o_kind      = r_o_kind;
    assign o_out_seq   = r_o_seq;
    assign o_out_handle = r_o_handle;
    assign o_lost_mask = r_o_mask;
    assign o_truncated = r_o_trunc;
    assign o_last      = r_o_last;

    always_comb begin
        diff_abs = (r_in_seq >= r_last_recv) ? {1'b0, r_in_seq - r_last_recv}
                                             : {1'b0, r_last_recv - r_in_seq};
        wrap_lim = 17'd65535 - {2'b00, r_jump_tol} + {1'b0, r_last_recv};
        if (r_last_recv >= {1'b0, r_jump_tol}) begin
            old_pkt = r_in_seq <= r_last_recv;
        end else begin
            old_pkt = (r_in_seq <= r_last_recv) || ({1'b0, r_in_seq} > wrap_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repair_pt <= 7'd99;
            r_jump_tol  <= 15'd100;
            r_wait_lim  <= 10'd40;
            r_nack_per  <= 10'd5;
            r_skip_lim  <= 10'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rtprb_pkg::CFG_REPAIR_PT: r_repair_pt <= i_cfg_data[6:0];
                rtprb_pkg::CFG_JUMP_TOL:  r_jump_tol  <= i_cfg_data;
                rtprb_pkg::CFG_WAIT_LIM:  r_wait_lim  <= i_cfg_data[9:0];
                rtprb_pkg::CFG_NACK_PER:  r_nack_per  <= i_cfg_data[9:0];
                rtprb_pkg::CFG_SKIP_LIM:  r_skip_lim  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rtprb_pkg::S_CLEAR;
            r_started    <= 1'b0;
            r_expected   <= '0;
            r_last_recv  <= '0;
            r_last_out   <= '0;
            r_wait_ticks <= '0;
            r_nack_ticks <= '0;
            r_cursor     <= '0;
            r_pv         <= 1'b0;
            r_ov         <= 1'b0;
            r_n          <= '0;
            r_made       <= '0;
            r_pend       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_started    <= n_started;
            r_expected   <= n_expected;
            r_last_recv  <= n_last_recv;
            r_last_out   <= n_last_out;
            r_wait_ticks <= n_wait_ticks;
            r_nack_ticks <= n_nack_ticks;
            r_cursor     <= n_cursor;
            r_pv         <= n_pv;
            r_ov         <= n_ov;
            r_n          <= n_n;
            r_made       <= n_made;
            r_pend       <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_seq    <= n_in_seq;
        r_in_handle <= n_in_handle;
        r_pid       <= n_pid;
        r_mask      <= n_mask;
        r_mbit      <= n_mbit;
        r_skip_cnt  <= n_skip_cnt;
        r_cap       <= n_cap;
        r_skipped   <= n_skipped;
        r_do_nack   <= n_do_nack;
        r_p_kind    <= n_p_kind;
        r_p_seq     <= n_p_seq;
        r_p_handle  <= n_p_handle;
        r_p_mask    <= n_p_mask;
        r_p_trunc   <= n_p_trunc;
        r_o_kind    <= n_o_kind;
        r_o_seq     <= n_o_seq;
        r_o_handle  <= n_o_handle;
        r_o_mask    <= n_o_mask;
        r_o_trunc   <= n_o_trunc;
        r_o_last    <= n_o_last;
    end

    always_comb begin
        n_state = r_state;
        n_started = r_started;
        n_expected = r_expected;
        n_last_recv = r_last_recv;
        n_last_out = r_last_out;
        n_wait_ticks = r_wait_ticks;
        n_nack_ticks = r_nack_ticks;
        n_in_seq = r_in_seq;
        n_in_handle = r_in_handle;
        n_cursor = r_cursor;
        n_pid = r_pid;
        n_mask = r_mask;
        n_mbit = r_mbit;
        n_skip_cnt = r_skip_cnt;
        n_n = r_n;
        n_made = r_made;
        n_cap = r_cap;
        n_skipped = r_skipped;
        n_pend = r_pend;
        n_do_nack = r_do_nack;
        n_pv = r_pv;
        n_p_kind = r_p_kind;
        n_p_seq = r_p_seq;
        n_p_handle = r_p_handle;
        n_p_mask = r_p_mask;
        n_p_trunc = r_p_trunc;
        n_ov = r_ov;
        n_o_kind = r_o_kind;
        n_o_seq = r_o_seq;
        n_o_handle = r_o_handle;
        n_o_mask = r_o_mask;
        n_o_trunc = r_o_trunc;
        n_o_last = r_o_last;
        s_addr = r_expected;
        s_we = 1'b0;
        s_wvalid = 1'b0;
        s_hen = 1'b0;

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        // pending result: forward once the next is known (or at finish)
        unique case (r_state)
            rtprb_pkg::S_CLEAR: begin
                s_addr = r_cursor[15:0];
                s_we = 1'b1;
                n_cursor = r_cursor + 17'd1;
                if (r_cursor[15:0] == 16'hFFFF) begin
                    n_state = rtprb_pkg::S_IDLE;
                end
            end
            rtprb_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_in_seq = i_seq_num;
                    n_in_handle = i_buf_handle;
                    if (!i_req_type) begin
                        if (i_payload_kind != r_repair_pt) begin
                            n_state = rtprb_pkg::S_ARR_RD;
                        end
                    end else if (r_started) begin
                        n_n = '0;
                        n_made = '0;
                        n_pend = 1'b0;
                        n_skipped = 1'b0;
                        n_do_nack = r_nack_ticks >= r_nack_per;
                        n_nack_ticks = (r_nack_ticks >= r_nack_per) ? '0
                                                                    : r_nack_ticks + 10'd1;
                        n_state = rtprb_pkg::S_DR_RD;
                    end
                end
            end
            rtprb_pkg::S_ARR_RD: begin
                n_state = rtprb_pkg::S_ARR_WR;
                if (r_started) begin
                    if (diff_abs > {2'b00, r_jump_tol}) begin
                        n_expected = r_in_seq;
                    end else if (old_pkt) begin
                        n_state = rtprb_pkg::S_IDLE;
                    end
                end else begin
                    n_started = 1'b1;
                    n_expected = r_in_seq;
                end
            end
            rtprb_pkg::S_ARR_WR: begin
                s_addr = r_in_seq;
                s_we = 1'b1;
                s_wvalid = 1'b1;
                s_hen = 1'b1;
                n_last_recv = r_in_seq;
                n_state = rtprb_pkg::S_IDLE;
            end
            rtprb_pkg::S_DR_RD: begin
                s_addr = r_expected;
                n_state = (r_n < CNT_BITS'(RELEASE_BURST)) ? rtprb_pkg::S_DR_CHK
                                                          : rtprb_pkg::S_TR_RD;
            end
            rtprb_pkg::S_DR_CHK: begin
                s_addr = r_expected;
                if (s_valid) begin
                    n_state = rtprb_pkg::S_DR_HRD;
                end else if (r_n == '0 && !r_skipped) begin
                    n_state = rtprb_pkg::S_WAIT_DEC;
                end else begin
                    n_state = rtprb_pkg::S_TR_RD;
                end
            end
            rtprb_pkg::S_DR_HRD, rtprb_pkg::S_SK_HRD: begin
                s_addr = r_expected;
                s_we = 1'b1;
                s_wvalid = 1'b0;
                n_state = (r_state == rtprb_pkg::S_DR_HRD) ? rtprb_pkg::S_DR_OUT
                                                          : rtprb_pkg::S_SK_OUT;
            end
            rtprb_pkg::S_DR_OUT, rtprb_pkg::S_SK_OUT, rtprb_pkg::S_NK_OUT: begin
                if (!r_pend || out_free) begin
                    if (r_pend) begin
                        n_ov = 1'b1;
                        n_o_kind = r_p_kind;
                        n_o_seq = r_p_seq;
                        n_o_handle = r_p_handle;
                        n_o_mask = r_p_mask;
                        n_o_trunc = r_p_trunc;
                        n_o_last = 1'b0;
                    end
                    n_pend = 1'b1;
                    n_n = r_n + CNT_BITS'(1);
                    if (r_state == rtprb_pkg::S_NK_OUT) begin
                        n_p_kind = 1'b1;
                        n_p_seq = r_pid;
                        n_p_handle = '0;
                        n_p_mask = r_mask;
                        n_made = r_made + CNT_BITS'(1);
                        n_state = rtprb_pkg::S_NK_CHK;
                    end else begin
                        n_p_kind = 1'b0;
                        n_p_seq = r_expected;
                        n_p_handle = s_handle;
                        n_p_mask = '0;
                        n_last_out = r_expected;
                        n_expected = r_expected + 16'd1;
                        n_wait_ticks = '0;
                        n_state = rtprb_pkg::S_DR_RD;
                    end
                    n_p_trunc = 1'b0;
                end
            end
            rtprb_pkg::S_WAIT_DEC: begin
                if (r_wait_ticks >= r_wait_lim) begin
                    n_wait_ticks = '0;
                    n_skip_cnt = '0;
                    n_skipped = 1'b1;
                    n_state = rtprb_pkg::S_SK_STEP;
                end else begin
                    n_wait_ticks = r_wait_ticks + 10'd1;
                    n_state = rtprb_pkg::S_TR_RD;
                end
            end
            rtprb_pkg::S_SK_STEP: begin
                if (r_skip_cnt >= r_skip_lim || r_expected == r_last_recv + 16'd1) begin
                    n_expected = r_last_recv + 16'd1;
                    n_state = rtprb_pkg::S_TR_RD;
                end else begin
                    n_expected = r_expected + 16'd1;
                    n_skip_cnt = r_skip_cnt + 10'd1;
                    n_state = rtprb_pkg::S_SK_RD;
                end
            end
            rtprb_pkg::S_SK_RD: begin
                s_addr = r_expected;
                n_state = rtprb_pkg::S_SK_CHK;
            end
            rtprb_pkg::S_SK_CHK: begin
                s_addr = r_expected;
                n_state = s_valid ? rtprb_pkg::S_SK_HRD : rtprb_pkg::S_SK_STEP;
            end
            rtprb_pkg::S_TR_RD: begin
                s_addr = r_expected;
                n_state = rtprb_pkg::S_TR_CHK;
            end
            rtprb_pkg::S_TR_CHK: begin
                s_addr = r_expected;
                if (r_n >= CNT_BITS'(RELEASE_BURST) && s_valid) begin
                    n_p_trunc = 1'b1;
                end
                n_state = r_do_nack ? rtprb_pkg::S_NK_START : rtprb_pkg::S_FIN_FLAG;
            end
            rtprb_pkg::S_NK_START: begin
                n_cursor = {1'b0, r_last_out + 16'd1};
                n_cap = (CNT_BITS'(rtprb_pkg::RESULT_CAP) - r_n < CNT_BITS'(NACK_ITEMS))
                      ? CNT_BITS'(rtprb_pkg::RESULT_CAP) - r_n : CNT_BITS'(NACK_ITEMS);
                n_state = rtprb_pkg::S_NK_RD;
            end
            rtprb_pkg::S_NK_RD: begin
                s_addr = r_cursor[15:0];
                if (r_cursor < {1'b0, r_last_recv}) begin
                    n_state = rtprb_pkg::S_NK_CHK;
                end else begin
                    n_state = rtprb_pkg::S_FIN_FLAG;
                end
            end
            rtprb_pkg::S_NK_CHK: begin
                // entered from S_NK_RD (data ready) or from S_NK_OUT (advance)
                s_addr = r_cursor[15:0];
                if (r_pv) begin
                    n_pv = 1'b0;
                    n_cursor = r_cursor + 17'd1;
                    n_state = rtprb_pkg::S_NK_RD;
                end else if (!s_valid) begin
                    if (r_made >= r_cap) begin
                        if (r_made != '0) begin
                            n_p_trunc = 1'b1;
                        end
                        n_state = rtprb_pkg::S_FIN_FLAG;
                    end else begin
                        n_pid = r_cursor[15:0];
                        n_mask = '0;
                        n_mbit = '0;
                        n_state = rtprb_pkg::S_NK_MRD;
                    end
                end else begin
                    n_cursor = r_cursor + 17'd1;
                    n_state = rtprb_pkg::S_NK_RD;
                end
            end
            rtprb_pkg::S_NK_MRD: begin
                if (r_mbit == 5'(rtprb_pkg::MASK_SPAN)) begin
                    n_state = rtprb_pkg::S_NK_OUT;
                end else begin
                    n_cursor = r_cursor + 17'd1;
                    s_addr = r_cursor[15:0] + 16'd1;
                    if (r_cursor + 17'd1 == {1'b0, r_last_recv}) begin
                        n_state = rtprb_pkg::S_NK_OUT;
                    end else begin
                        n_state = rtprb_pkg::S_NK_MCHK;
                    end
                end
            end
            rtprb_pkg::S_NK_MCHK: begin
                s_addr = r_cursor[15:0];
                if (!s_valid) begin
                    n_mask = r_mask | (16'h8000 >> r_mbit[3:0]);
                end
                n_mbit = r_mbit + 5'd1;
                n_state = rtprb_pkg::S_NK_MRD;
            end
            rtprb_pkg::S_NK_EMIT: begin
                n_state = rtprb_pkg::S_NK_OUT;
            end
            rtprb_pkg::S_FIN_FLAG: begin
                n_state = rtprb_pkg::S_FIN_OUT;
            end
            rtprb_pkg::S_FIN_OUT: begin
                if (!r_pend) begin
                    n_state = rtprb_pkg::S_IDLE;
                end else if (out_free) begin
                    n_ov = 1'b1;
                    n_o_kind = r_p_kind;
                    n_o_seq = r_p_seq;
                    n_o_handle = r_p_handle;
                    n_o_mask = r_p_mask;
                    n_o_trunc = r_p_trunc;
                    n_o_last = 1'b1;
                    n_pend = 1'b0;
                    n_state = rtprb_pkg::S_IDLE;
                end
            end
            default: n_state = rtprb_pkg::S_IDLE;
        endcase

        // NACK item just queued: cursor steps past it on the next check
        if (r_state == rtprb_pkg::S_NK_OUT && (!r_pend || out_free)) begin
            n_pv = 1'b1;
        end
    end
endmodule
`default_nettype wire

[rtl/rtprb_checker.sv]
// Port checker for the RTP reorder buffer, bound to the top level.
`default_nettype none
module rtprb_checker #(
    parameter int HANDLE_BITS = 16
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   o_ready,
    input wire                   o_valid,
    input wire                   i_ready,
    input wire                   o_kind,
    input wire [15:0]            o_out_seq,
    input wire [HANDLE_BITS-1:0] o_out_handle,
    input wire [15:0]            o_lost_mask,
    input wire                   o_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_seq))
        else $error("result word dropped while stalled");
    a_nack_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_out_handle == '0)
        else $error("NACK word carries a handle");
    a_rel_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_lost_mask == '0)
        else $error("release word carries a mask");
    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && o_valid |-> o_last)
        else $error("block idle with a tick unfinished");
endmodule

bind rtp_reorder_buffer_nack rtprb_checker #(.HANDLE_BITS(HANDLE_BITS)) u_rtprb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_kind(o_kind), .o_out_seq(o_out_seq),
    .o_out_handle(o_out_handle), .o_lost_mask(o_lost_mask), .o_last(o_last)
);
`default_nettype wire
